// ===== rtl/core/apr_pkg.sv =====
package apr_pkg;

  localparam int FRAC_BITS = 16;

  localparam int SUM_W  = 32;
  localparam int RAYS_W = 16;
  localparam int THR_W  = 17;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;

  localparam int FULL_SCALE = 255;
  localparam int FULL_SQ    = 65025;

  localparam logic [IDX_W-1:0] REG_SHADOW_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SHADOW_HIGH = IDX_W'(1);

  typedef struct packed {
    logic [SUM_W-1:0]  red_sum;
    logic [SUM_W-1:0]  green_sum;
    logic [SUM_W-1:0]  blue_sum;
    logic [SUM_W-1:0]  alpha_sum;
    logic [RAYS_W-1:0] ray_count;
  } apr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
  } apr_out_t;

endpackage

// ===== rtl/core/accumulated_pixel_resolve_core.sv =====
// Resolves one accumulated pixel to 8-bit RGBA. Accepts one word per clock
// while in_stall is low and passes each word through one stage of constant
// multiplies (sum*65025 and sum*255 scaled down by the fraction bits, and the
// threshold products), then eight stages of a bit-serial search, one result
// bit per stage, that finds the largest square root byte for each colour and
// the alpha byte by shift-and-add only. The last search stage drives the output
// word directly. The whole pipe advances unless the output word is stalled.
// Thresholds may only be written while the pipe is empty.
module accumulated_pixel_resolve_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  apr_pkg::apr_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output apr_pkg::apr_out_t     out_data,
  input  logic                  cfg_we,
  input  logic [apr_pkg::IDX_W-1:0] cfg_index,
  input  logic [apr_pkg::THR_W-1:0] cfg_wdata
);
  import apr_pkg::*;

  localparam int PW  = 48 - FRAC_BITS;
  localparam int PAW = 40 - FRAC_BITS;
  localparam int CW  = (PW > 34) ? PW : 34;
  localparam int NST = 8;

  typedef struct packed {
    logic [31:0] q;
    logic [23:0] rr;
    logic [7:0]  r;
  } sqs_t;

  typedef struct packed {
    logic [23:0] l;
    logic [7:0]  k;
  } lin_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 lo_hit;
    logic                 hi_hit;
    logic [RAYS_W-1:0]    rays;
    logic [2:0][PW-1:0]   p;
    logic [PAW-1:0]       pa;
    sqs_t [2:0]           sq;
    lin_t                 lin;
  } stg_t;

  function automatic sqs_t sq_step(sqs_t s, logic [PW-1:0] p, logic [RAYS_W-1:0] rays,
                                   int j);
    logic [33:0] cand;
    sqs_t        o;
    cand = 34'(s.q) + (34'(s.rr) << (j + 1)) + (34'(rays) << (2 * j));
    o = s;
    if (CW'(cand) <= CW'(p)) begin
      o.q  = cand[31:0];
      o.rr = s.rr + (24'(rays) << j);
      o.r  = s.r | (8'(1) << j);
    end
    return o;
  endfunction

  function automatic lin_t lin_step(lin_t s, logic [PAW-1:0] pa, logic [RAYS_W-1:0] rays,
                                    int j);
    logic [32:0] cand;
    lin_t        o;
    cand = 33'(s.l) + (33'(rays) << j);
    o = s;
    if (cand <= 33'(pa)) begin
      o.l = cand[23:0];
      o.k = s.k | (8'(1) << j);
    end
    return o;
  endfunction

  logic [THR_W-1:0] shadow_low_r, shadow_high_r;
  stg_t             st_r [0:NST];
  logic [SUM_W-1:0] a0_r;
  logic [32:0]      lowp_r, highp_r;
  logic             adv;
  stg_t             front_nxt;
  stg_t             st_nxt [1:NST];
  logic [63:0]      a_shift;
  logic [SUM_W-1:0] sums [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_low_r  <= '0;
      shadow_high_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_SHADOW_LOW)  shadow_low_r  <= cfg_wdata;
      if (cfg_index == REG_SHADOW_HIGH) shadow_high_r <= cfg_wdata;
    end
  end

  assign adv      = !(st_r[NST].valid && out_stall);
  assign in_stall = !adv;

  assign sums[0] = in_data.red_sum;
  assign sums[1] = in_data.green_sum;
  assign sums[2] = in_data.blue_sum;

  always_comb begin
    front_nxt       = '0;
    front_nxt.valid = in_valid;
    front_nxt.rays  = in_data.ray_count;
    front_nxt.zero  = (in_data.ray_count == '0) ||
                      (in_data.red_sum == '0 && in_data.green_sum == '0 &&
                       in_data.blue_sum == '0);
    for (int c = 0; c < 3; c++) begin
      front_nxt.p[c] = PW'((48'(sums[c]) * 48'(FULL_SQ)) >> FRAC_BITS);
    end
    front_nxt.pa = PAW'((40'(in_data.alpha_sum) * 40'(FULL_SCALE)) >> FRAC_BITS);
  end

  assign a_shift = 64'(a0_r) << 16;

  always_comb begin
    st_nxt[1]        = st_r[0];
    st_nxt[1].lo_hit = (shadow_low_r != '0) && (a_shift < (64'(lowp_r) << FRAC_BITS));
    st_nxt[1].hi_hit = (shadow_high_r != '0) && (a_shift > (64'(highp_r) << FRAC_BITS));
    for (int c = 0; c < 3; c++) begin
      st_nxt[1].sq[c] = sq_step(st_r[0].sq[c], st_r[0].p[c], st_r[0].rays, NST - 1);
    end
    st_nxt[1].lin = lin_step(st_r[0].lin, st_r[0].pa, st_r[0].rays, NST - 1);
  end

  for (genvar s = 2; s <= NST; s++) begin : g_step
    always_comb begin
      st_nxt[s] = st_r[s-1];
      for (int c = 0; c < 3; c++) begin
        st_nxt[s].sq[c] = sq_step(st_r[s-1].sq[c], st_r[s-1].p[c], st_r[s-1].rays,
                                  NST - s);
      end
      st_nxt[s].lin = lin_step(st_r[s-1].lin, st_r[s-1].pa, st_r[s-1].rays, NST - s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NST; s++) st_r[s].valid <= 1'b0;
    end else if (adv) begin
      st_r[0] <= front_nxt;
      a0_r    <= in_data.alpha_sum;
      lowp_r  <= 33'(shadow_low_r) * 33'(in_data.ray_count);
      highp_r <= 33'(shadow_high_r) * 33'(in_data.ray_count);
      for (int s = 1; s <= NST; s++) st_r[s] <= st_nxt[s];
    end
  end

  assign out_valid = st_r[NST].valid;

  always_comb begin
    out_data = '0;
    if (!st_r[NST].zero) begin
      out_data.red_out   = st_r[NST].sq[0].r;
      out_data.green_out = st_r[NST].sq[1].r;
      out_data.blue_out  = st_r[NST].sq[2].r;
      priority if (st_r[NST].lo_hit) out_data.alpha_out = '0;
      else if (st_r[NST].hi_hit)     out_data.alpha_out = BYTE_W'(FULL_SCALE);
      else                           out_data.alpha_out = st_r[NST].lin.k;
    end
  end

endmodule
